// ----- design/gsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_pkg
// Types, constants and helpers shared by the separable Gaussian filter.
// ----------------------------------------------------------------------------
package gsf_pkg;

  localparam int NCOEF = 6;   // centre weight plus five distance weights
  localparam int CFG_AW = 5;  // eight 32-bit registers
  localparam int COEF_W = 17;
  localparam int FW_W = 12;   // frame_width register
  localparam int FH_W = 13;   // frame_height register
  localparam int RW = 14;     // row counters, which run up to height + radius
  localparam int PW = 25;     // 8-bit sample times 17-bit weight
  localparam int SW = 29;     // sum of up to fifteen products

  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [PW-1:0] r;
    logic [PW-1:0] g;
    logic [PW-1:0] b;
  } prod_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } out_item_t;

  // Reflect-with-edge: -1 maps to 0 and n maps to n-1, then clamp.
  function automatic logic signed [15:0] mirror(input logic signed [15:0] pos,
                                                input logic signed [15:0] n);
    logic signed [15:0] p;
    p = pos;
    if (p < 0) p = -p - 16'sd1;
    if (p >= n) p = 16'(2 * n - 16'sd1 - p);
    if (p < 0) p = 16'sd0;
    if (p >= n) p = n - 16'sd1;
    return p;
  endfunction

  // Drop the sixteen fraction bits and saturate at 255.
  function automatic logic [7:0] scale_sat(input logic [SW-1:0] acc);
    logic [SW-1:0] t;
    t = acc >> 16;
    return (t > SW'(255)) ? 8'hFF : t[7:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/gsf_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gsf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/gsf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_ram
// Single-port RAM with registered, read-before-write output.
// ----------------------------------------------------------------------------
module gsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

// ----- design/gsf_mac_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_mac_cell
// One filter tap: weight times an RGB sample, registered per channel.
// ----------------------------------------------------------------------------
module gsf_mac_cell (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire gsf_pkg::rgb_t                sample,
  input  wire logic [gsf_pkg::COEF_W-1:0]   weight,
  output gsf_pkg::prod_t                    prod
);
  import gsf_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod.r <= PW'(sample.r) * PW'(weight);
      prod.g <= PW'(sample.g) * PW'(weight);
      prod.b <= PW'(sample.b) * PW'(weight);
    end
  end
endmodule
`default_nettype wire

// ----- design/gsf_tap_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_tap_cell
// One stage of the horizontal pixel window plus its tap multiplier.
// ----------------------------------------------------------------------------
module gsf_tap_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift,
  input  wire gsf_pkg::rgb_t                pix_in,
  output gsf_pkg::rgb_t                     pix_out,
  input  wire logic                         en,
  input  wire gsf_pkg::rgb_t                sample,
  input  wire logic [gsf_pkg::COEF_W-1:0]   weight,
  output gsf_pkg::prod_t                    prod
);
  import gsf_pkg::*;

  rgb_t pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;

  gsf_mac_cell u_mac (
    .clk    (clk),
    .en     (en),
    .sample (sample),
    .weight (weight),
    .prod   (prod)
  );
endmodule
`default_nettype wire

// ----- design/gsf_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_sum
// Two-level registered adder tree over the tap products, then scaling.
// ----------------------------------------------------------------------------
module gsf_sum #(
  parameter int N = 11
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire gsf_pkg::prod_t prods [N],
  output gsf_pkg::rgb_t       res
);
  import gsf_pkg::*;

  localparam int G = (N + 3) / 4;

  logic [SW-1:0] l1r_r [G];
  logic [SW-1:0] l1g_r [G];
  logic [SW-1:0] l1b_r [G];
  logic [SW-1:0] l1r_nxt [G];
  logic [SW-1:0] l1g_nxt [G];
  logic [SW-1:0] l1b_nxt [G];
  logic [SW-1:0] tr, tg, tb;

  always_comb begin
    for (int g = 0; g < G; g++) begin
      l1r_nxt[g] = '0;
      l1g_nxt[g] = '0;
      l1b_nxt[g] = '0;
      for (int m = 0; m < 4; m++) begin
        if (g * 4 + m < N) begin
          l1r_nxt[g] = l1r_nxt[g] + SW'(prods[g * 4 + m].r);
          l1g_nxt[g] = l1g_nxt[g] + SW'(prods[g * 4 + m].g);
          l1b_nxt[g] = l1b_nxt[g] + SW'(prods[g * 4 + m].b);
        end
      end
    end
    tr = '0;
    tg = '0;
    tb = '0;
    for (int g = 0; g < G; g++) begin
      tr = tr + l1r_r[g];
      tg = tg + l1g_r[g];
      tb = tb + l1b_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1r_r <= l1r_nxt;
      l1g_r <= l1g_nxt;
      l1b_r <= l1b_nxt;
      res.r <= scale_sat(tr);
      res.g <= scale_sat(tg);
      res.b <= scale_sat(tb);
    end
  end
endmodule
`default_nettype wire

// ----- design/separable_gaussian_filter_rgb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// separable_gaussian_filter_rgb
// Separable (2*RADIUS+1)-tap Gaussian blur on an 8-bit RGB raster stream.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and gives at most one result per
// clock while the output is not stalled. Throughput is set by the single port
// of each line buffer bank, which every advance reads while only the bank of
// the current row is written. The horizontal pass is a row of tap
// cells holding the pixel window; its results go into 2*RADIUS RAM banks of
// MAX_WIDTH entries, one per buffered row, and the vertical pass reads all
// banks at the same column. Send frame_height*frame_width pixels, then flush
// transactions until the pixel marked last_pixel has come out. The line
// buffers need no clearing after reset.
module separable_gaussian_filter_rgb #(
  parameter int RADIUS    = 5,
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  gsf_stream_if.sink                        in_chan,
  gsf_stream_if.source                      out_chan,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gsf_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import gsf_pkg::*;

  localparam int TAPS = 2 * RADIUS + 1;
  localparam int NB   = 2 * RADIUS;
  localparam int IW   = $clog2(TAPS);
  localparam int BW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int LW   = $clog2(RADIUS + 1);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int NST  = 7;

  typedef struct packed {
    logic                       have_cur;
    logic                       emit;
    logic                       last;
    logic [AW-1:0]              col;
    logic [BW-1:0]              wbank;
    logic [TAPS-1:0][IW-1:0]    hsel;
    logic [TAPS-1:0]            vcur;
    logic [TAPS-1:0][BW-1:0]    vbank;
  } desc_t;

  // Configuration
  logic [COEF_W-1:0] coef_r [NCOEF];
  logic [FW_W-1:0]   width_r;
  logic [FH_W-1:0]   height_r;
  logic [2:0]        cfg_idx;

  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= (i == 0) ? COEF_W'(65536) : '0;
      width_r   <= FW_W'(640);
      height_r  <= FH_W'(480);
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[FW_W-1:0];
        REG_HEIGHT: height_r <= pwdata[FH_W-1:0];
        default:    coef_r[cfg_idx] <= pwdata[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = 32'(coef_r[cfg_idx]);
    endcase
  end

  // Effective frame size
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  always_comb begin
    if (width_r == '0) eff_w = CW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(width_r);
    eff_h = (height_r == '0) ? RW'(1) : RW'(height_r);
  end

  // Tap weights
  logic [COEF_W-1:0] wt [TAPS];
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      if ((t - RADIUS) < NCOEF && (RADIUS - t) < NCOEF)
        wt[t] = coef_r[(t >= RADIUS) ? (t - RADIUS) : (RADIUS - t)];
      else
        wt[t] = '0;
    end
  end

  // Handshake and position counters
  logic en, acc, is_pix, step, lag_done, tick;
  logic have_cur, emit, last;
  rgb_t fresh;
  logic out_valid_r;

  logic [CW-1:0] in_col_r, in_col_nxt, hz_col_r, hz_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, hz_row_r, hz_row_nxt;
  logic [LW-1:0] hz_lag_r, hz_lag_nxt;
  logic [BW-1:0] hz_bank_r, hz_bank_nxt;

  assign en  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;
  assign acc = in_chan.valid && en;
  assign is_pix = (in_chan.data.cmd == CMD_PIXEL);
  assign step = acc && (is_pix ? (in_row_r < eff_h) : (in_row_r >= eff_h));
  assign lag_done = (hz_lag_r == LW'(RADIUS));
  assign tick = step && lag_done;
  assign have_cur = hz_row_r < eff_h;
  assign emit = hz_row_r >= RW'(RADIUS);
  assign last = emit && (hz_row_r == eff_h + RW'(RADIUS) - RW'(1))
                && (hz_col_r == eff_w - CW'(1));

  always_comb begin
    fresh = '0;
    if (is_pix) begin
      fresh.r = in_chan.data.in_red;
      fresh.g = in_chan.data.in_green;
      fresh.b = in_chan.data.in_blue;
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    hz_col_nxt  = hz_col_r;
    hz_row_nxt  = hz_row_r;
    hz_lag_nxt  = hz_lag_r;
    hz_bank_nxt = hz_bank_r;
    if (step && is_pix) begin
      if (in_col_r + CW'(1) >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (step && !lag_done) hz_lag_nxt = hz_lag_r + LW'(1);
    if (tick) begin
      if (hz_col_r + CW'(1) >= eff_w) begin
        hz_col_nxt  = '0;
        hz_row_nxt  = hz_row_r + RW'(1);
        hz_bank_nxt = (32'(hz_bank_r) == NB - 1) ? '0 : hz_bank_r + BW'(1);
      end else begin
        hz_col_nxt = hz_col_r + CW'(1);
      end
      // End of frame, either on the last output or when the rows run out.
      if (last || hz_row_nxt >= eff_h + RW'(RADIUS)) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        hz_col_nxt  = '0;
        hz_row_nxt  = '0;
        hz_lag_nxt  = '0;
        hz_bank_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      hz_col_r  <= '0;
      hz_row_r  <= '0;
      hz_lag_r  <= '0;
      hz_bank_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      hz_col_r  <= hz_col_nxt;
      hz_row_r  <= hz_row_nxt;
      hz_lag_r  <= hz_lag_nxt;
      hz_bank_r <= hz_bank_nxt;
    end
  end

  // Tap selection for this tick, with border mirroring in both directions.
  desc_t d0;
  always_comb begin
    logic signed [15:0] cs, ws, hs, rs, rws, pos, ix, j, dd, bk;
    cs  = signed'(16'(hz_col_r));
    ws  = signed'(16'(eff_w));
    hs  = signed'(16'(eff_h));
    rws = signed'(16'(hz_row_r));
    rs  = rws - 16'(RADIUS);
    d0.have_cur = have_cur;
    d0.emit     = emit;
    d0.last     = last;
    d0.col      = (hz_col_r >= CW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : hz_col_r[AW-1:0];
    d0.wbank    = hz_bank_r;
    for (int t = 0; t < TAPS; t++) begin
      pos = mirror(cs + 16'(t - RADIUS), ws);
      ix  = pos - cs + 16'(RADIUS);
      if (ix < 0) ix = 16'sd0;
      if (ix > TAPS - 1) ix = 16'(TAPS - 1);
      d0.hsel[t] = IW'(ix);
      j  = mirror(rs + 16'(t - RADIUS), hs);
      d0.vcur[t] = have_cur && (j == rws);
      dd = rws - j;
      if (dd < 0) dd = 16'sd0;
      if (dd > NB) dd = 16'(NB);
      bk = signed'(16'(hz_bank_r)) - dd;
      if (bk < 0) bk = bk + 16'(NB);
      d0.vbank[t] = BW'(bk);
    end
  end

  logic  vld_r [NST];
  desc_t dp_r  [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= tick && (have_cur || emit);
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r[0] <= d0;
      for (int s = 1; s < NST; s++) dp_r[s] <= dp_r[s-1];
    end
  end

  // Horizontal pass: window cells, newest pixel enters at the top.
  rgb_t  win   [TAPS];
  rgb_t  hsamp [TAPS];
  prod_t hprod [TAPS];
  rgb_t  cur;

  genvar t;
  generate
    for (t = 0; t < TAPS; t++) begin : g_hcell
      rgb_t pin;
      if (t == TAPS - 1) begin : g_top
        assign pin = fresh;
      end else begin : g_mid
        assign pin = win[t+1];
      end
      assign hsamp[t] = win[dp_r[0].hsel[t]];
      gsf_tap_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (step),
        .pix_in  (pin),
        .pix_out (win[t]),
        .en      (en),
        .sample  (hsamp[t]),
        .weight  (wt[t]),
        .prod    (hprod[t])
      );
    end
  endgenerate

  gsf_sum #(.N(TAPS)) u_hsum (
    .clk   (clk),
    .en    (en),
    .prods (hprod),
    .res   (cur)
  );

  // Line buffers: one bank per buffered row, all read at the same column.
  rgb_t bank_q [NB];
  rgb_t cur_d_r;

  always_ff @(posedge clk) begin
    if (en) cur_d_r <= cur;
  end

  genvar b;
  generate
    for (b = 0; b < NB; b++) begin : g_bank
      logic we;
      assign we = en && vld_r[3] && dp_r[3].have_cur && (32'(dp_r[3].wbank) == b);
      gsf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram (
        .clk   (clk),
        .en    (en),
        .we    (we),
        .addr  (dp_r[3].col),
        .wdata (cur),
        .rdata (bank_q[b])
      );
    end
  endgenerate

  // Vertical pass
  rgb_t  vsamp [TAPS];
  prod_t vprod [TAPS];
  rgb_t  vres;

  generate
    for (t = 0; t < TAPS; t++) begin : g_vcell
      assign vsamp[t] = dp_r[4].vcur[t] ? cur_d_r : bank_q[dp_r[4].vbank[t]];
      gsf_mac_cell u_mac (
        .clk    (clk),
        .en     (en),
        .sample (vsamp[t]),
        .weight (wt[t]),
        .prod   (vprod[t])
      );
    end
  endgenerate

  gsf_sum #(.N(TAPS)) u_vsum (
    .clk   (clk),
    .en    (en),
    .prods (vprod),
    .res   (vres)
  );

  // Output register
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NST-1] && dp_r[NST-1].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_last_r <= dp_r[NST-1].last;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.data.out_red    = vres.r;
  assign out_chan.data.out_green  = vres.g;
  assign out_chan.data.out_blue   = vres.b;
  assign out_chan.data.last_pixel = out_last_r;
endmodule
`default_nettype wire
